// ----- design/siv_pkg.sv -----
// Shared types and constants for the section image validator.
`timescale 1ns / 1ps

package siv_pkg;

	// Largest slot count accepted in the image
	localparam int unsigned MAX_SECTIONS  = 1024;
	// Width of slot counters and of the reported section count
	localparam int unsigned CNT_W         = $clog2(MAX_SECTIONS + 1);
	// Magic length and per-slot header length in bytes
	localparam int unsigned MAGIC_BYTES   = 4;
	localparam int unsigned SEC_HDR_BYTES = 25;
	// Bytes ahead of the slot headers: magic plus two 32-bit counts
	localparam int unsigned FILE_HDR_BYTES = 12;
	// Byte positions of the begin and end offsets inside one slot header
	localparam int unsigned BEGIN_FIRST   = 9;
	localparam int unsigned BEGIN_LAST    = 16;
	localparam int unsigned END_FIRST     = 17;
	localparam int unsigned END_LAST      = 24;
	// Result bus width, rounded up to whole bytes
	localparam int unsigned OUT_W         = ((3 + CNT_W + 7) / 8) * 8;

	// File magic, byte by byte
	localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h73, 8'h74, 8'h62, 8'h01};

	// Parser phase
	typedef enum logic [5:0] {
		PH_MAGIC   = 6'b000001,
		PH_SLOTS   = 6'b000010,
		PH_USED    = 6'b000100,
		PH_HEADERS = 6'b001000,
		PH_GAPS    = 6'b010000,
		PH_DATA    = 6'b100000
	} phase_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EARLY_END = 3'd1,
		ST_MAGIC     = 3'd2,
		ST_COUNT     = 3'd3,
		ST_OFFSET    = 3'd4,
		ST_GAP       = 3'd5
	} status_t;

	// One input byte with its end-of-file flag
	typedef struct packed {
		logic       final_byte;
		logic [7:0] data_byte;
	} item_t;

	// One validation result
	typedef struct packed {
		logic [CNT_W-1:0] sections_found;
		status_t          status;
	} result_t;

	// Checker state seen by the top level
	typedef struct packed {
		phase_t  phase;
		status_t err;
	} chk_mon_t;

endpackage

// ----- design/siv_in_stage.sv -----
// Input register stage of the section image validator.
`timescale 1ns / 1ps

module siv_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] data_byte
	input  logic          s_tlast,
	input  logic          advance,
	output logic          valid_s1,
	output siv_pkg::item_t item_s1
);
	import siv_pkg::*;

	// Free when empty or when the held byte moves on this cycle
	assign s_tready = !valid_s1 || advance;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte  <= s_tdata;
			item_s1.final_byte <= s_tlast;
		end
	end

endmodule

// ----- design/siv_check.sv -----
// Byte-wise image parser and checker with first-error latch.
`timescale 1ns / 1ps

module siv_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  siv_pkg::item_t    item,
	output siv_pkg::result_t  result,
	output siv_pkg::chk_mon_t mon
);
	import siv_pkg::*;

	phase_t           phase_q,  phase_nx;
	logic [4:0]       pos_q,    pos_nx;
	logic [CNT_W-1:0] idx_q,    idx_nx;
	logic [CNT_W-1:0] lim_q,    lim_nx;
	logic [CNT_W-1:0] used_q,   used_nx;
	logic [63:0]      exp_q,    exp_nx;
	logic [63:0]      fld_q,    fld_nx;
	logic [63:0]      beg_q,    beg_nx;
	logic [63:0]      tot_q,    tot_nx;
	logic             bad_q,    bad_nx;
	status_t          err_q,    err_nx;
	logic [7:0]       b;
	logic [31:0]      cnt;
	logic [CNT_W+4:0] hdr_area;
	logic [2:0]       lane_b;
	logic [2:0]       lane_e;

	// Phase after a slot is done: used headers first, then zero slots, then data
	function automatic phase_t slot_phase(input logic [CNT_W-1:0] idx,
			input logic [CNT_W-1:0] used, input logic [CNT_W-1:0] lim);
		phase_t ph;
		if (idx < used) begin
			ph = PH_HEADERS;
		end else if (idx < lim) begin
			ph = PH_GAPS;
		end else begin
			ph = PH_DATA;
		end
		return ph;
	endfunction

	// Next-state logic for one byte
	always_comb begin
		phase_nx = phase_q;
		pos_nx   = pos_q;
		idx_nx   = idx_q;
		lim_nx   = lim_q;
		used_nx  = used_q;
		exp_nx   = exp_q;
		fld_nx   = fld_q;
		beg_nx   = beg_q;
		bad_nx   = bad_q;
		err_nx   = err_q;
		tot_nx   = tot_q + 64'd1;
		b        = item.data_byte;
		cnt      = 32'd0;
		lane_b   = 3'(pos_q - 5'(BEGIN_FIRST));
		lane_e   = 3'(pos_q - 5'(END_FIRST));
		// 12 + 25 * slots; 25x is 16x + 8x + x
		hdr_area = (CNT_W+5)'({lim_q, 4'b0000}) + (CNT_W+5)'({lim_q, 3'b000})
			+ (CNT_W+5)'(lim_q) + (CNT_W+5)'(FILE_HDR_BYTES);

		if (err_q == ST_OK) begin
			unique case (phase_q) inside
				PH_MAGIC: begin
					bad_nx = bad_q | (b != MAGIC[pos_q[1:0]]);
					if (pos_q == 5'(MAGIC_BYTES - 1)) begin
						if (bad_nx) begin
							err_nx = ST_MAGIC;
						end else begin
							phase_nx = PH_SLOTS;
						end
						pos_nx = 5'd0;
						bad_nx = 1'b0;
					end else begin
						pos_nx = pos_q + 5'd1;
					end
				end
				PH_SLOTS, PH_USED: begin
					fld_nx[{pos_q[1:0], 3'b000} +: 8] = b;
					cnt = fld_nx[31:0];
					if (pos_q == 5'd3) begin
						if (phase_q == PH_SLOTS) begin
							if (cnt == 32'd0 || cnt > 32'(MAX_SECTIONS)) begin
								err_nx = ST_COUNT;
							end else begin
								lim_nx   = cnt[CNT_W-1:0];
								phase_nx = PH_USED;
							end
						end else begin
							if (cnt > 32'(lim_q)) begin
								err_nx = ST_COUNT;
							end else begin
								used_nx  = cnt[CNT_W-1:0];
								exp_nx   = 64'(hdr_area);
								idx_nx   = '0;
								phase_nx = slot_phase('0, cnt[CNT_W-1:0], lim_q);
							end
						end
						fld_nx = 64'd0;
						pos_nx = 5'd0;
					end else begin
						pos_nx = pos_q + 5'd1;
					end
				end
				PH_HEADERS: begin
					if (pos_q >= 5'(BEGIN_FIRST) && pos_q <= 5'(BEGIN_LAST)) begin
						beg_nx[{lane_b, 3'b000} +: 8] = b;
					end else if (pos_q >= 5'(END_FIRST) && pos_q <= 5'(END_LAST)) begin
						fld_nx[{lane_e, 3'b000} +: 8] = b;
					end
					if (pos_q >= 5'(SEC_HDR_BYTES - 1)) begin
						if (beg_nx != exp_q || fld_nx < beg_nx) begin
							err_nx = ST_OFFSET;
						end else begin
							exp_nx   = fld_nx;
							idx_nx   = idx_q + 1'b1;
							phase_nx = slot_phase(idx_nx, used_q, lim_q);
						end
						beg_nx = 64'd0;
						fld_nx = 64'd0;
						pos_nx = 5'd0;
					end else begin
						pos_nx = pos_q + 5'd1;
					end
				end
				PH_GAPS: begin
					bad_nx = bad_q | (b != 8'd0);
					if (pos_q >= 5'(SEC_HDR_BYTES - 1)) begin
						if (bad_nx) begin
							err_nx = ST_GAP;
						end else begin
							idx_nx   = idx_q + 1'b1;
							phase_nx = slot_phase(idx_nx, used_q, lim_q);
						end
						bad_nx = 1'b0;
						pos_nx = 5'd0;
					end else begin
						pos_nx = pos_q + 5'd1;
					end
				end
				PH_DATA: begin
					// data bytes are only counted
				end
				default: begin
				end
			endcase
		end
	end

	// Status for a byte that ends the file
	always_comb begin
		if (err_nx != ST_OK) begin
			result.status = err_nx;
		end else if (phase_nx != PH_DATA) begin
			result.status = ST_EARLY_END;
		end else if (tot_nx != exp_nx) begin
			result.status = ST_OFFSET;
		end else begin
			result.status = ST_OK;
		end
		result.sections_found = used_nx;
	end

	assign mon.phase = phase_q;
	assign mon.err   = err_q;

	// State registers; the final byte rearms everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			pos_q   <= 5'd0;
			idx_q   <= '0;
			lim_q   <= '0;
			used_q  <= '0;
			exp_q   <= 64'd0;
			fld_q   <= 64'd0;
			beg_q   <= 64'd0;
			tot_q   <= 64'd0;
			bad_q   <= 1'b0;
			err_q   <= ST_OK;
		end else if (step) begin
			if (item.final_byte) begin
				phase_q <= PH_MAGIC;
				pos_q   <= 5'd0;
				idx_q   <= '0;
				lim_q   <= '0;
				used_q  <= '0;
				exp_q   <= 64'd0;
				fld_q   <= 64'd0;
				beg_q   <= 64'd0;
				tot_q   <= 64'd0;
				bad_q   <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_nx;
				pos_q   <= pos_nx;
				idx_q   <= idx_nx;
				lim_q   <= lim_nx;
				used_q  <= used_nx;
				exp_q   <= exp_nx;
				fld_q   <= fld_nx;
				beg_q   <= beg_nx;
				tot_q   <= tot_nx;
				bad_q   <= bad_nx;
				err_q   <= err_nx;
			end
		end
	end

endmodule

// ----- design/section_image_validator_unit.sv -----
// Output: the status of a file reaches m_tdata once its final byte has passed through
//   the input register and then the result register.
// Throughput: one byte per cycle; the input register holds only a final byte
//   whose result register is still occupied by an untaken status.
// Reset: arst_n clears all parser state and empties both registers; after each
//   final byte the parser rearms to the same state for the next file.
`timescale 1ns / 1ps

module section_image_validator_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // [7:0] data_byte
	input  logic                      s_tlast,   // final_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [siv_pkg::OUT_W-1:0] m_tdata    // [2:0] status, then sections_found, zero pad
);
	import siv_pkg::*;

	logic     valid_s1;
	item_t    item_s1;
	logic     out_free;
	logic     advance;
	result_t  result;
	chk_mon_t mon;
	result_t  res_q;

	// A byte moves on unless it ends a file and the result slot is taken
	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && (!item_s1.final_byte || out_free);

	siv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	siv_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result),
		.mon    (mon)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= advance && item_s1.final_byte;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance && item_s1.final_byte) begin
			res_q <= result;
		end
	end

	assign m_tdata = OUT_W'(res_q);

	// A latched error holds until the file ends
	a_err_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(mon.err != ST_OK && !(advance && item_s1.final_byte)) |=> (mon.err == $past(mon.err)))
		else $error("latched error changed before end of file");

	// The final byte rearms the parser
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.final_byte) |=> (mon.phase == PH_MAGIC && mon.err == ST_OK))
		else $error("parser not rearmed after final byte");

	// Only defined status codes leave the block
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_q.status <= ST_GAP))
		else $error("undefined status code on output");

	// A count error leaves no section count behind
	a_count_err: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.status == ST_COUNT) |-> (res_q.sections_found == '0))
		else $error("section count reported with count error");

endmodule
